### design/ibs_pkg.sv
// ----------------------------------------------------------------------------
// Incremental bounding sphere package
// Widths of the fixed-point datapath and the control word of the shared
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package ibs_pkg;

  // Field widths of the transfers.
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned DIAM_W       = 32;
  localparam int unsigned DIMS_DEFAULT = 2;

  // Magnitude of a coordinate difference.
  localparam int unsigned MAG_W   = COORD_W + 1;
  // Shared multiplier: full A operand times one half of the B operand.
  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = MUL_A_W / 2;
  localparam int unsigned ACC_W   = 2 * MUL_A_W;
  // Squared distance, its root and the scaling division.
  localparam int unsigned RAD_W   = 2 * MAG_W;
  localparam int unsigned ROOT_W  = RAD_W / 2 + 1;
  localparam int unsigned NUM_W   = 2 * ROOT_W;
  localparam int unsigned DEN_W   = ROOT_W + 2;
  localparam int unsigned QUO_W   = COORD_W;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic clear;
    logic upper;
  } mac_ctl_t;

endpackage

### design/ibs_if.sv
// ----------------------------------------------------------------------------
// Incremental bounding sphere channels
// Point input channel and ball result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ibs_in_if;
  import ibs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic        [DIAM_W-1:0]  seed_diameter;

  modport source (output valid, operation, coord_x, coord_y, coord_z, seed_diameter,
                  input ready);
  modport sink (input valid, operation, coord_x, coord_y, coord_z, seed_diameter,
                output ready);
endinterface

interface ibs_out_if;
  import ibs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic        [DIAM_W-1:0]  ball_diameter;
  logic                      grew;

  modport source (output valid, center_x, center_y, center_z, ball_diameter, grew,
                  input ready);
  modport sink (input valid, center_x, center_y, center_z, ball_diameter, grew,
                output ready);
endinterface

### design/ibs_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Multiplies the A operand by one half of the B operand per cycle and, while
// enabled, adds the shifted partial product into a wide accumulator or, on clear, loads it.
// ----------------------------------------------------------------------------
module ibs_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ibs_pkg::mac_ctl_t                  ctl_i,
  input  logic [ibs_pkg::MUL_A_W-1:0]        a_i,
  input  logic [ibs_pkg::MUL_A_W-1:0]        b_i,
  output logic [ibs_pkg::ACC_W-1:0]          acc_o
);
  import ibs_pkg::*;

  logic [MUL_B_W-1:0]         b_half;
  logic [MUL_A_W+MUL_B_W-1:0] prod;
  logic [ACC_W-1:0]           term;
  logic [ACC_W-1:0]           acc_d, acc_q;

  // Partial product of the selected half, aligned to its weight.
  always_comb begin
    b_half = ctl_i.upper ? b_i[MUL_A_W-1:MUL_B_W] : b_i[MUL_B_W-1:0];
    prod   = a_i * b_half;
    term   = ctl_i.upper ? (ACC_W'(prod) << MUL_B_W) : ACC_W'(prod);
    acc_d  = ctl_i.clear ? term : acc_q + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### design/ibs_sqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit root, one result bit per cycle, floor of the exact root.
// ----------------------------------------------------------------------------
module ibs_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ibs_pkg::RAD_W-1:0]   rad_i,
  output logic                        done_o,
  output logic [ibs_pkg::ROOT_W-1:0]  root_o
);
  import ibs_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W);
  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned SH_W  = REM_W + 2;

  logic              run_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SH_W-1:0]   rem_sh, trial, rem_sub;
  logic              ge;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh  = {rem_q, rad_q[NUM_W-1 -: 2]};
    trial   = SH_W'({root_q, 2'b01});
    ge      = rem_sh >= trial;
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(ROOT_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= NUM_W'(rad_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### design/ibs_div.sv
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Divides a wide numerator by a denominator, one quotient bit per cycle.
// The quotient is known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
module ibs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ibs_pkg::NUM_W-1:0]   num_i,
  input  logic [ibs_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [ibs_pkg::QUO_W-1:0]   quo_o
);
  import ibs_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic             run_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [QUO_W-1:0] sh_q;
  logic [DEN_W:0]   t, t_sub;
  logic             ge;

  // Shift one numerator bit into the remainder and compare.
  always_comb begin
    t     = {rem_q, sh_q[QUO_W-1]};
    ge    = t >= {1'b0, den_q};
    t_sub = t - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(QUO_W - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and numerator/quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[NUM_W-1:QUO_W];
      sh_q  <= num_i[QUO_W-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= ge ? t_sub[DEN_W-1:0] : t[DEN_W-1:0];
      sh_q  <= {sh_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = sh_q;

endmodule

### design/incremental_bounding_sphere_core.sv
// Sequence: a seed passes the start and finish steps; an extend first squares the
// diameter and the distance and compares them, and one that grows the ball then
// runs the root unit (34 root steps) and the divider (32 steps per coordinate).
// Throughput: one item at a time; the next input transfer is taken once the
// result is handed to the output register. Reset clears the ball to center zero
// and diameter zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Incremental bounding sphere core
// Keeps a running bounding ball and grows it Ritter-style for each point that
// lies outside, using one shared multiplier, a root unit and a divider.
// ----------------------------------------------------------------------------
module incremental_bounding_sphere_core #(
  parameter int unsigned DIMS = ibs_pkg::DIMS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ibs_in_if.sink    in_i,
  ibs_out_if.source out_o
);
  import ibs_pkg::*;

  localparam int unsigned DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_START = 11'b000_0000_0010,
    S_DD    = 11'b000_0000_0100,
    S_SQ    = 11'b000_0000_1000,
    S_CMP   = 11'b000_0001_0000,
    S_SQRT  = 11'b000_0010_0000,
    S_SCALE = 11'b000_0100_0000,
    S_PM    = 11'b000_1000_0000,
    S_DIV   = 11'b001_0000_0000,
    S_MOVE  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_e;

  state_e state_q;

  // Item latched at the input transfer.
  logic              item_op_q;
  logic [COORD_W-1:0] item_c_q [3];
  logic [DIAM_W-1:0] item_sd_q;

  // Ball state and per-item working registers.
  logic [COORD_W-1:0] center_q [DIMS];
  logic [DIAM_W-1:0]  diam_q;
  logic               neg_q [DIMS];
  logic [MAG_W-1:0]   mag_q [DIMS];
  logic [2*DIAM_W-1:0] dd_q;
  logic [ROOT_W-1:0]  dist_q;
  logic [ROOT_W:0]    m_q;
  logic [DEN_W-1:0]   den_q;
  logic [DIM_W-1:0]   dim_q;
  logic               half_q;
  logic               grew_q;

  // Output register.
  logic               out_valid_q;
  logic [COORD_W-1:0] out_cx_q, out_cy_q, out_cz_q;
  logic [DIAM_W-1:0]  out_d_q;
  logic               out_grew_q;

  // Units.
  mac_ctl_t           mac_ctl;
  logic [MUL_A_W-1:0] mac_a, mac_b;
  logic [ACC_W-1:0]   acc;
  logic               sq_start, sq_done;
  logic [ROOT_W-1:0]  root;
  logic               div_start, div_done;
  logic [QUO_W-1:0]   quo;

  logic               in_xfer, out_free, dim_last, outside;
  logic [MAG_W-1:0]   dif [DIMS];
  logic [ROOT_W:0]    dist2, m_new;
  logic [ROOT_W+1:0]  dsum;
  logic [ROOT_W:0]    nd;
  logic [MAG_W-1:0]   qc;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign dim_last = dim_q == DIM_W'(DIMS - 1);
  assign outside  = {acc[RAD_W-1:0], 2'b00} > (RAD_W + 2)'(dd_q);

  // Coordinate differences and their magnitudes.
  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      dif[i] = {item_c_q[i][COORD_W-1], item_c_q[i]} - {center_q[i][COORD_W-1], center_q[i]};
    end
  end

  // Growth terms from the floored root.
  always_comb begin
    dist2 = {dist_q, 1'b0};
    dsum  = (ROOT_W + 2)'(diam_q) + (ROOT_W + 2)'(dist2);
    nd    = dsum[ROOT_W+1:1];
    m_new = (dist2 > (ROOT_W + 1)'(diam_q)) ? dist2 - (ROOT_W + 1)'(diam_q) : '0;
    qc    = (MAG_W'(quo) > mag_q[dim_q]) ? mag_q[dim_q] : MAG_W'(quo);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mac_ctl.en    = (state_q == S_DD) || (state_q == S_SQ) || (state_q == S_PM);
    mac_ctl.upper = half_q;
    mac_ctl.clear = !half_q && ((state_q == S_DD) || (state_q == S_PM) ||
                                ((state_q == S_SQ) && (dim_q == '0)));
    mac_a = MUL_A_W'(mag_q[dim_q]);
    mac_b = MUL_A_W'(mag_q[dim_q]);
    unique case (state_q)
      S_DD: begin
        mac_a = MUL_A_W'(diam_q);
        mac_b = MUL_A_W'(diam_q);
      end
      S_PM: begin
        mac_b = MUL_A_W'(m_q);
      end
      default: begin
      end
    endcase
  end

  assign sq_start  = (state_q == S_CMP) && outside;
  assign div_start = (state_q == S_DIV) && !half_q;

  ibs_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  ibs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (acc[RAD_W-1:0]),
    .done_o  (sq_done),
    .root_o  (root)
  );

  ibs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc[NUM_W-1:0]),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Input item capture.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_op_q   <= in_i.operation;
      item_c_q[0] <= in_i.coord_x;
      item_c_q[1] <= in_i.coord_y;
      item_c_q[2] <= in_i.coord_z;
      item_sd_q   <= in_i.seed_diameter;
    end
  end

  // Sequencer and ball state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      diam_q  <= '0;
      dim_q   <= '0;
      half_q  <= 1'b0;
      grew_q  <= 1'b0;
      for (int i = 0; i < DIMS; i++) begin
        center_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          grew_q <= 1'b0;
          dim_q  <= '0;
          half_q <= 1'b0;
          if (!item_op_q) begin
            for (int i = 0; i < DIMS; i++) begin
              center_q[i] <= item_c_q[i];
            end
            diam_q  <= item_sd_q;
            state_q <= S_FIN;
          end else begin
            state_q <= S_DD;
          end
        end
        S_DD: begin
          half_q <= !half_q;
          if (half_q) begin
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          half_q <= !half_q;
          if (half_q) begin
            if (dim_last) begin
              dim_q   <= '0;
              state_q <= S_CMP;
            end else begin
              dim_q <= dim_q + 1'b1;
            end
          end
        end
        S_CMP: begin
          state_q <= outside ? S_SQRT : S_FIN;
        end
        S_SQRT: begin
          if (sq_done) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          grew_q  <= 1'b1;
          diam_q  <= (nd[ROOT_W:DIAM_W] != '0) ? '1 : nd[DIAM_W-1:0];
          dim_q   <= '0;
          half_q  <= 1'b0;
          state_q <= ((m_new != '0) && (dist_q != '0)) ? S_PM : S_FIN;
        end
        S_PM: begin
          half_q <= !half_q;
          if (half_q) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          half_q <= 1'b1;
          if (div_done) begin
            state_q <= S_MOVE;
          end
        end
        S_MOVE: begin
          center_q[dim_q] <= neg_q[dim_q] ? center_q[dim_q] - qc[COORD_W-1:0]
                                          : center_q[dim_q] + qc[COORD_W-1:0];
          half_q <= 1'b0;
          if (dim_last) begin
            state_q <= S_FIN;
          end else begin
            dim_q   <= dim_q + 1'b1;
            state_q <= S_PM;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers of the extend path.
  always_ff @(posedge clk_i) begin
    if (state_q == S_START) begin
      for (int i = 0; i < DIMS; i++) begin
        neg_q[i] <= dif[i][MAG_W-1];
        mag_q[i] <= dif[i][MAG_W-1] ? (~dif[i] + 1'b1) : dif[i];
      end
    end
    if ((state_q == S_SQ) && (dim_q == '0) && !half_q) begin
      dd_q <= acc[2*DIAM_W-1:0];
    end
    if (sq_done) begin
      dist_q <= root;
    end
    if (state_q == S_SCALE) begin
      m_q   <= m_new;
      den_q <= {dist_q, 2'b00};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && out_free) begin
      out_cx_q   <= center_q[0];
      out_cy_q   <= center_q[1];
      out_d_q    <= diam_q;
      out_grew_q <= grew_q;
    end
  end

  // Third coordinate only exists for three-dimensional balls.
  if (DIMS > 2) begin : g_z
    always_ff @(posedge clk_i) begin
      if ((state_q == S_FIN) && out_free) begin
        out_cz_q <= center_q[2];
      end
    end
  end else begin : g_no_z
    assign out_cz_q = '0;
  end

  assign in_i.ready          = state_q == S_IDLE;
  assign out_o.valid         = out_valid_q;
  assign out_o.center_x      = out_cx_q;
  assign out_o.center_y      = out_cy_q;
  assign out_o.center_z      = out_cz_q;
  assign out_o.ball_diameter = out_d_q;
  assign out_o.grew          = out_grew_q;

  // The block stays busy after taking an item.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("input taken while an item is in progress");

  // A new result appears only from the finish step.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside the finish step");

  // Units report completion only while the sequencer waits for them.
  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_SQRT))
    else $error("root finished outside its wait step");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("division finished outside its wait step");

  // The diameter holds while no item is in progress.
  a_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(diam_q))
    else $error("diameter changed while idle");

endmodule
